// ===== design/mei_pkg.sv =====
// Shared types and constants for the escape-time iteration block.
// Fixed-point format, datapath widths, queue item and result records.
// No dependencies.
package mei_pkg;

  // Point coordinates: signed, FRAC_BITS fraction bits (Q4.28)
  localparam int FRAC_BITS = 28;
  localparam int C_W       = 32;
  localparam int CNT_W     = 12;

  // |z| stays below 4 + |c| while not escaped, so this magnitude width is exact
  localparam int MAG_W  = ((FRAC_BITS + 2 > C_W - 1) ? FRAC_BITS + 2 : C_W - 1) + 1;
  localparam int Z_W    = MAG_W + 1;
  localparam int PROD_W = 2 * MAG_W;
  // |z|^2 >= 4 once any sum bit at or above this weight is set
  localparam int ESC_BIT = 2 * FRAC_BITS + 2;

  // Configuration port
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;
  localparam logic [ADDR_W-1:0] REG_MAX_ITER_ADDR = 3'd0;

  typedef struct packed {
    logic                  skip;    // limit is zero: no iterations to run
    logic signed [C_W-1:0] c_real;
    logic signed [C_W-1:0] c_imag;
  } mei_item_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             in_set;
  } mei_result_t;

endpackage

// ===== design/mandelbrot_escape_iterations.sv =====
// Top level of the escape-time iteration block: config register, front queue,
// iteration core and output register. Depends on mei_pkg, mei_front, mei_core.
//
//   channel  direction  handshake           payload
//   in       sink       in_valid/in_stall   c_real, c_imag (signed Q4.28)
//   out      source     out_valid/out_stall iteration_count, inside_set
//   cfg      APB slave  psel/penable/pready paddr, pwdata, prdata
//
// Each point is popped in the idle state, then runs one product state and one
// update state per iteration, then a result state; the escape test that stops
// a point costs one more product/update pair. A zero limit goes straight from
// the pop to the result state. The queue entry and the output register each
// add a register on the way through.
// rst is synchronous; it empties the queue, idles the core and restores the
// limit to RESET_MAX_ITER. The queue keeps taking transfers while the core is
// busy, and the core finishes its next point while a result sits stalled.
module mandelbrot_escape_iterations import mei_pkg::*; #(
  parameter int QUEUE_DEPTH    = 2,
  parameter int RESET_MAX_ITER = 1000
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic signed [C_W-1:0] c_real,
  input  logic signed [C_W-1:0] c_imag,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [CNT_W-1:0]      iteration_count,
  output logic                  inside_set,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_W-1:0]     paddr,
  input  logic [DATA_W-1:0]     pwdata,
  output logic [DATA_W-1:0]     prdata,
  output logic                  pready
);

  logic [CNT_W-1:0] max_iterations;
  logic             q_valid;
  mei_item_t        q_item;
  logic             q_pop;
  logic             res_valid;
  mei_result_t      res;
  logic             res_take;

  // config: single register, zero-wait writes
  assign pready = 1'b1;
  assign prdata = (paddr == REG_MAX_ITER_ADDR) ? DATA_W'(max_iterations) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_iterations <= CNT_W'(RESET_MAX_ITER);
    end else if (psel && penable && pwrite && pready && paddr == REG_MAX_ITER_ADDR) begin
      max_iterations <= pwdata[CNT_W-1:0];
    end
  end

  mei_front #(
    .DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .max_iterations (max_iterations),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .c_real         (c_real),
    .c_imag         (c_imag),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .q_pop          (q_pop)
  );

  mei_core u_core (
    .clk            (clk),
    .rst            (rst),
    .max_iterations (max_iterations),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .q_pop          (q_pop),
    .res_valid      (res_valid),
    .res            (res),
    .res_take       (res_take)
  );

  // output register: loads when empty or when its transfer completes
  assign res_take = res_valid && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      iteration_count <= res.count;
      inside_set      <= res.in_set;
    end
  end

endmodule

// ===== design/mei_front.sv =====
// Front end: accepts points, tags them and holds them in a short queue.
// Depends on mei_pkg.
module mei_front import mei_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [CNT_W-1:0]       max_iterations,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic signed [C_W-1:0]  c_real,
  input  logic signed [C_W-1:0]  c_imag,
  output logic                   q_valid,
  output mei_item_t              q_item,
  input  logic                   q_pop
);

  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FILL_W = $clog2(DEPTH + 1);

  mei_item_t         slots [DEPTH];
  logic [IDX_W-1:0]  wr_ptr;
  logic [IDX_W-1:0]  rd_ptr;
  logic [FILL_W-1:0] fill;
  logic              push;

  assign in_stall = (fill == FILL_W'(DEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (fill != '0);
  assign q_item   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr].skip   <= (max_iterations == '0);
      slots[wr_ptr].c_real <= c_real;
      slots[wr_ptr].c_imag <= c_imag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= (rd_ptr == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !q_pop) begin
        fill <= fill + 1'b1;
      end else if (!push && q_pop) begin
        fill <= fill - 1'b1;
      end
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_W'(DEPTH))
    else $error("queue fill beyond depth");

  a_fill_up: assert property (@(posedge clk) disable iff (rst)
    push && !q_pop |=> fill == $past(fill) + 1'b1)
    else $error("queue fill did not count a push");

endmodule

// ===== design/mei_core.sv =====
// Back end: iterates z = z*z + c on one queued point at a time.
// Each iteration runs products, then escape test and update. Depends on mei_pkg.
module mei_core import mei_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic [CNT_W-1:0] max_iterations,
  input  logic             q_valid,
  input  mei_item_t        q_item,
  output logic             q_pop,
  output logic             res_valid,
  output mei_result_t      res,
  input  logic             res_take
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL  = 4'b0010,
    S_UPD  = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

  state_t state, state_next;

  logic signed [C_W-1:0]  cr, ci;
  logic signed [Z_W-1:0]  zr, zi;
  logic [CNT_W-1:0]       count;
  logic [PROD_W-1:0]      sr, si, cross_prod;
  logic                   sgn;

  logic [MAG_W-1:0]        mr, mi;
  logic [PROD_W:0]         mag_sum;
  logic                    escaped;
  logic signed [PROD_W:0]  diff, diff_sh;
  logic [PROD_W+1:0]       two_mag;
  logic signed [PROD_W+1:0] two_s, two_sh;
  logic signed [Z_W-1:0]   nr, ni;
  logic [CNT_W-1:0]        count_inc;

  // magnitudes feed unsigned multipliers; sign handled on the cross term
  assign mr = zr[Z_W-1] ? MAG_W'(-zr) : MAG_W'(zr);
  assign mi = zi[Z_W-1] ? MAG_W'(-zi) : MAG_W'(zi);

  assign mag_sum = {1'b0, sr} + {1'b0, si};
  assign escaped = |mag_sum[PROD_W:ESC_BIT];

  // floor shifts match the arithmetic right shift of the exact products
  assign diff    = $signed({1'b0, sr}) - $signed({1'b0, si});
  assign diff_sh = diff >>> FRAC_BITS;
  assign nr      = $signed(diff_sh[Z_W-1:0]) + $signed({{(Z_W-C_W){cr[C_W-1]}}, cr});

  assign two_mag = {1'b0, cross_prod, 1'b0};
  assign two_s   = sgn ? $signed(-two_mag) : $signed(two_mag);
  assign two_sh  = two_s >>> FRAC_BITS;
  assign ni      = $signed(two_sh[Z_W-1:0]) + $signed({{(Z_W-C_W){ci[C_W-1]}}, ci});

  assign count_inc = count + 1'b1;

  assign q_pop      = (state == S_IDLE) && q_valid;
  assign res_valid  = (state == S_FIN);
  assign res.count  = count;
  assign res.in_set = (count == max_iterations);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (q_valid) state_next = q_item.skip ? S_FIN : S_MUL;
      end
      S_MUL: state_next = S_UPD;
      S_UPD: begin
        if (escaped || count_inc == max_iterations) state_next = S_FIN;
        else state_next = S_MUL;
      end
      S_FIN: begin
        if (res_take) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cr    <= q_item.c_real;
      ci    <= q_item.c_imag;
      zr    <= '0;
      zi    <= '0;
      count <= '0;
    end
    if (state == S_MUL) begin
      sr         <= PROD_W'(mr * mr);
      si         <= PROD_W'(mi * mi);
      cross_prod <= PROD_W'(mr * mi);
      sgn        <= zr[Z_W-1] ^ zi[Z_W-1];
    end
    if (state == S_UPD && !escaped) begin
      zr    <= nr;
      zi    <= ni;
      count <= count_inc;
    end
  end

  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid && state == S_IDLE)
    else $error("queue popped outside idle");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    state == S_UPD && !escaped |=> count == $past(count_inc))
    else $error("iteration count did not advance");

  a_mul_entry: assert property (@(posedge clk) disable iff (rst)
    state == S_MUL |-> $past(state) == S_IDLE || $past(state) == S_UPD)
    else $error("product stage entered from wrong state");

endmodule
